// ----- rtl/ocbc_pkg.sv -----
// Shared types and constants for the one-rotor byte cipher.
package ocbc_pkg;

	localparam int BYTE_W     = 8;
	localparam int ROTOR_SIZE = 256;
	localparam int IDX_W      = $clog2(ROTOR_SIZE);

	typedef logic [BYTE_W-1:0] byte_t;

	typedef enum logic [1:0] {
		OP_LOAD_ROT = 2'd0,
		OP_LOAD_REF = 2'd1,
		OP_CIPHER   = 2'd2
	} opcode_t;

	// One classified item in the queue
	typedef struct packed {
		opcode_t kind;
		byte_t   idx;
		byte_t   val;
		byte_t   addr;   // rotor read address for cipher items
		byte_t   n1;
		byte_t   n2;
	} entry_t;

	typedef struct packed {
		byte_t n1;
		byte_t n2;
	} ctr_stat_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	typedef struct packed {
		logic stall;
		logic pop;
	} back_stat_t;

endpackage

// ----- rtl/ocbc_front.sv -----
// Front end: accepts items, drops unknown opcodes, stamps cipher items with the counters.
module ocbc_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          opcode,
	input  ocbc_pkg::byte_t     entry_index,
	input  ocbc_pkg::byte_t     entry_value,
	input  ocbc_pkg::fifo_stat_t fifo_stat,
	output logic                push,
	output ocbc_pkg::entry_t    push_entry,
	output ocbc_pkg::ctr_stat_t ctr
);

	ocbc_pkg::byte_t n1_q;
	ocbc_pkg::byte_t n2_q;
	logic            known;
	logic            is_cipher;
	logic            accept;

	always_comb begin
		known     = 1'b0;
		is_cipher = 1'b0;
		unique case (opcode)
			ocbc_pkg::OP_LOAD_ROT, ocbc_pkg::OP_LOAD_REF: known = 1'b1;
			ocbc_pkg::OP_CIPHER: begin
				known     = 1'b1;
				is_cipher = 1'b1;
			end
			default: known = 1'b0;
		endcase
	end

	assign in_ready = !fifo_stat.full;
	assign accept   = in_valid && in_ready;
	assign push     = accept && known;

	always_comb begin
		push_entry.kind = ocbc_pkg::opcode_t'(opcode);
		push_entry.idx  = entry_index;
		push_entry.val  = entry_value;
		push_entry.addr = entry_value + n1_q;
		push_entry.n1   = n1_q;
		push_entry.n2   = n2_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n1_q <= '0;
			n2_q <= '0;
		end else if (accept && is_cipher) begin
			n1_q <= n1_q + 1'b1;
			if (n1_q == '1) begin
				n2_q <= n2_q + 1'b1;
			end
		end
	end

	assign ctr.n1 = n1_q;
	assign ctr.n2 = n2_q;

endmodule

// ----- rtl/ocbc_fifo.sv -----
// Short queue of classified items between the front end and the table pipeline.
module ocbc_fifo #(
	parameter int DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  ocbc_pkg::entry_t     push_entry,
	input  logic                 pop,
	output ocbc_pkg::entry_t     head,
	output ocbc_pkg::fifo_stat_t stat
);

	localparam int PW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	ocbc_pkg::entry_t mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign stat.full  = (count_q == CW'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/ocbc_back.sv -----
// Back end: three table stages (rotor, reflector, inverse rotor) and the output register.
module ocbc_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ocbc_pkg::entry_t     head,
	input  logic                 head_valid,
	output ocbc_pkg::back_stat_t stat,
	output logic                 out_valid,
	input  logic                 out_ready,
	output ocbc_pkg::byte_t      out_byte
);

	// Each table lives in exactly one stage; items pass in order, so a load
	// always lands before any later cipher item reads that table.
	ocbc_pkg::byte_t rot_mem [ocbc_pkg::ROTOR_SIZE];
	ocbc_pkg::byte_t ref_mem [ocbc_pkg::ROTOR_SIZE];
	ocbc_pkg::byte_t inv_mem [ocbc_pkg::ROTOR_SIZE];

	logic             valid_s1, valid_s2, valid_s3;
	ocbc_pkg::entry_t item_s1, item_s2, item_s3;
	ocbc_pkg::byte_t  rd_s1, rd_s2, rd_s3;
	logic             out_valid_q;
	ocbc_pkg::byte_t  out_byte_q;

	logic adv;
	logic pop;
	logic [ocbc_pkg::IDX_W-1:0] rot_addr, ref_addr, inv_addr;
	logic rot_we, ref_we, inv_we;
	logic rot_re, ref_re, inv_re;

	assign adv = !out_valid_q || out_ready;
	assign pop = adv && head_valid;

	always_comb begin
		rot_we   = pop && (head.kind == ocbc_pkg::OP_LOAD_ROT);
		rot_re   = pop && (head.kind == ocbc_pkg::OP_CIPHER);
		rot_addr = rot_we ? head.idx : head.addr;

		ref_we   = adv && valid_s1 && (item_s1.kind == ocbc_pkg::OP_LOAD_REF);
		ref_re   = adv && valid_s1 && (item_s1.kind == ocbc_pkg::OP_CIPHER);
		ref_addr = ref_we ? item_s1.idx : rd_s1 + item_s1.n2;

		inv_we   = adv && valid_s2 && (item_s2.kind == ocbc_pkg::OP_LOAD_ROT);
		inv_re   = adv && valid_s2 && (item_s2.kind == ocbc_pkg::OP_CIPHER);
		inv_addr = inv_we ? item_s2.val : rd_s2 - item_s2.n2;
	end

	always_ff @(posedge clk) begin
		if (rot_we) begin
			rot_mem[rot_addr] <= head.val;
		end
		if (rot_re) begin
			rd_s1 <= rot_mem[rot_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ref_we) begin
			ref_mem[ref_addr] <= item_s1.val;
		end
		if (ref_re) begin
			rd_s2 <= ref_mem[ref_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (inv_we) begin
			inv_mem[inv_addr] <= item_s2.idx;
		end
		if (inv_re) begin
			rd_s3 <= inv_mem[inv_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1 <= head;
			item_s2 <= item_s1;
			item_s3 <= item_s2;
			out_byte_q <= rd_s3 - item_s3.n1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= head_valid;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			out_valid_q <= valid_s3 && (item_s3.kind == ocbc_pkg::OP_CIPHER);
		end
	end

	assign stat.stall = !adv;
	assign stat.pop   = pop;
	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;

endmodule

// ----- rtl/one_rotor_byte_cipher_core.sv -----
// Top level: front end, item queue and table pipeline of the one-rotor byte cipher.
// Three stages hold one table read and one memory each: rotor, reflector, inverse rotor.
// Throughput: one item per cycle while out_ready does not stall the output register.
// The queue (QUEUE_DEPTH entries) absorbs input while the output is stalled.
// Reset clears both counters and all valid flags; the tables hold garbage until loaded.
module one_rotor_byte_cipher_core #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] opcode,
	input  logic [7:0] entry_index,
	input  logic [7:0] entry_value,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte
);

	logic                 push;
	ocbc_pkg::entry_t     push_entry;
	ocbc_pkg::entry_t     head;
	ocbc_pkg::ctr_stat_t  ctr;
	ocbc_pkg::fifo_stat_t fifo_stat;
	ocbc_pkg::back_stat_t back_stat;

	ocbc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (opcode),
		.entry_index(entry_index),
		.entry_value(entry_value),
		.fifo_stat  (fifo_stat),
		.push       (push),
		.push_entry (push_entry),
		.ctr        (ctr)
	);

	ocbc_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.pop       (back_stat.pop),
		.head      (head),
		.stat      (fifo_stat)
	);

	ocbc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.head_valid(!fifo_stat.empty),
		.stat      (back_stat),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte)
	);

	// Fast counter steps once per accepted cipher byte
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && opcode == ocbc_pkg::OP_CIPHER)
		|=> (ctr.n1 == $past(ctr.n1) + 8'd1))
	else $error("fast counter did not advance on cipher transfer");

	// Slow counter moves only when the fast counter wraps
	assert property (@(posedge clk) disable iff (!arst_n)
		(ctr.n2 != $past(ctr.n2)) |-> ($past(ctr.n1) == 8'hff && ctr.n1 == 8'h00))
	else $error("slow counter moved without fast counter wrap");

	// A stalled back end must not drain the queue
	assert property (@(posedge clk) disable iff (!arst_n)
		back_stat.stall |-> !back_stat.pop)
	else $error("queue popped while output stalled");

	// Queue cannot be full and empty at once
	assert property (@(posedge clk) disable iff (!arst_n)
		!(fifo_stat.full && fifo_stat.empty))
	else $error("queue status inconsistent");

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the one-rotor byte cipher core.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int STALL_LIMIT = 2000;
	localparam int TAIL_CYCLES = 12;
	localparam int PHASE_ITEMS = 210;

	typedef struct packed {
		logic [1:0]      op;
		ocbc_pkg::byte_t idx;
		ocbc_pkg::byte_t val;
		logic            typed;
		ocbc_pkg::byte_t out;
	} dir_row_t;

	// Hand-checked rows; typed outputs follow directly from the loads before them
	localparam dir_row_t DIRECTED [17] = '{
		'{ocbc_pkg::OP_LOAD_ROT, 8'h00, 8'h00, 1'b0, 8'h00},
		'{ocbc_pkg::OP_LOAD_REF, 8'h00, 8'h00, 1'b0, 8'h00},
		'{ocbc_pkg::OP_CIPHER,   8'hA5, 8'h00, 1'b1, 8'h00},
		'{ocbc_pkg::OP_CIPHER,   8'h00, 8'hFF, 1'b1, 8'hFF},
		'{OP_UNUSED,             8'hFF, 8'hFF, 1'b0, 8'h00},
		'{ocbc_pkg::OP_LOAD_ROT, 8'hFF, 8'hFF, 1'b0, 8'h00},
		'{ocbc_pkg::OP_LOAD_REF, 8'hFF, 8'hFF, 1'b0, 8'h00},
		'{ocbc_pkg::OP_LOAD_ROT, 8'h01, 8'hFE, 1'b0, 8'h00},
		'{ocbc_pkg::OP_CIPHER,   8'hFF, 8'hFD, 1'b1, 8'hFD},
		'{ocbc_pkg::OP_LOAD_ROT, 8'h03, 8'h01, 1'b0, 8'h00},
		'{ocbc_pkg::OP_LOAD_REF, 8'h01, 8'hFE, 1'b0, 8'h00},
		'{ocbc_pkg::OP_CIPHER,   8'h5A, 8'h00, 1'b1, 8'hFE},
		'{ocbc_pkg::OP_LOAD_REF, 8'hFE, 8'h01, 1'b0, 8'h00},
		'{ocbc_pkg::OP_CIPHER,   8'h3C, 8'hFD, 1'b0, 8'h00},
		'{ocbc_pkg::OP_LOAD_REF, 8'h07, 8'h00, 1'b0, 8'h00},
		// overwrite leaves the old inverse entry in place
		'{ocbc_pkg::OP_LOAD_ROT, 8'h00, 8'h07, 1'b0, 8'h00},
		'{ocbc_pkg::OP_CIPHER,   8'hC3, 8'hFB, 1'b0, 8'h00}
	};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [1:0] opcode = 2'd0;
	logic [7:0] entry_index = 8'd0;
	logic [7:0] entry_value = 8'd0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] out_byte;

	one_rotor_byte_cipher_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.opcode      (opcode),
		.entry_index (entry_index),
		.entry_value (entry_value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte)
	);

	always #6 clk = ~clk;

	// Cipher state mirror
	ocbc_pkg::byte_t rot_map  [ocbc_pkg::ROTOR_SIZE];
	ocbc_pkg::byte_t inv_map  [ocbc_pkg::ROTOR_SIZE];
	ocbc_pkg::byte_t refl_map [ocbc_pkg::ROTOR_SIZE];
	bit    rot_set  [ocbc_pkg::ROTOR_SIZE] = '{default: 1'b0};
	bit    inv_set  [ocbc_pkg::ROTOR_SIZE] = '{default: 1'b0};
	bit    refl_set [ocbc_pkg::ROTOR_SIZE] = '{default: 1'b0};
	ocbc_pkg::byte_t fast_n = 8'd0;
	ocbc_pkg::byte_t slow_n = 8'd0;

	ocbc_pkg::byte_t pending_out [$];
	ocbc_pkg::byte_t out_want;
	int    errors = 0;
	int    send_gap_pct = 0;
	int    recv_gap_pct = 0;
	int    sent_items = 0;
	int    quiet_cycles = 0;

	function automatic ocbc_pkg::byte_t cipher_byte(ocbc_pkg::byte_t b);
		ocbc_pkg::byte_t a;
		a = rot_map[ocbc_pkg::byte_t'(b + fast_n)];
		a = refl_map[ocbc_pkg::byte_t'(a + slow_n)];
		a = inv_map[ocbc_pkg::byte_t'(a - slow_n)];
		return ocbc_pkg::byte_t'(a - fast_n);
	endfunction

	// True when every table read for byte b hits a loaded entry
	function automatic bit chain_ready(ocbc_pkg::byte_t b);
		ocbc_pkg::byte_t i1, i2, i3;
		i1 = ocbc_pkg::byte_t'(b + fast_n);
		if (!rot_set[i1])
			return 1'b0;
		i2 = ocbc_pkg::byte_t'(rot_map[i1] + slow_n);
		if (!refl_set[i2])
			return 1'b0;
		i3 = ocbc_pkg::byte_t'(refl_map[i2] - slow_n);
		return inv_set[i3];
	endfunction

	function automatic void commit_item(logic [1:0] op, ocbc_pkg::byte_t idx,
			ocbc_pkg::byte_t val);
		case (op)
			ocbc_pkg::OP_LOAD_ROT: begin
				rot_map[idx] = val;
				rot_set[idx] = 1'b1;
				inv_map[val] = idx;
				inv_set[val] = 1'b1;
			end
			ocbc_pkg::OP_LOAD_REF: begin
				refl_map[idx] = val;
				refl_set[idx] = 1'b1;
			end
			ocbc_pkg::OP_CIPHER: begin
				fast_n = ocbc_pkg::byte_t'(fast_n + 1);
				if (fast_n == 8'd0)
					slow_n = ocbc_pkg::byte_t'(slow_n + 1);
			end
			default: ;
		endcase
	endfunction

	task automatic send_item(input logic [1:0] op, input ocbc_pkg::byte_t idx,
			input ocbc_pkg::byte_t val, input bit typed, input ocbc_pkg::byte_t typed_out);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		opcode      <= op;
		entry_index <= idx;
		entry_value <= val;
		do @(posedge clk); while (!in_ready);
		if (op == ocbc_pkg::OP_CIPHER)
			pending_out.push_back(typed ? typed_out : cipher_byte(val));
		commit_item(op, idx, val);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_out.size() != 0)
			@(posedge clk);
	endtask

	task automatic random_item();
		int    r;
		bit    found;
		ocbc_pkg::byte_t b, start, i, j;
		r = $urandom_range(99);
		if (r < 4) begin
			send_item(OP_UNUSED, ocbc_pkg::byte_t'($urandom), ocbc_pkg::byte_t'($urandom),
				1'b0, 8'd0);
			return;
		end
		found = 1'b0;
		b = 8'd0;
		if (r >= 34) begin
			for (int k = 0; k < 16 && !found; k++) begin
				b = ocbc_pkg::byte_t'($urandom);
				found = chain_ready(b);
			end
			start = ocbc_pkg::byte_t'($urandom);
			for (int k = 0; k < ocbc_pkg::ROTOR_SIZE && !found; k++) begin
				b = ocbc_pkg::byte_t'(start + k);
				found = chain_ready(b);
			end
		end
		if (found) begin
			send_item(ocbc_pkg::OP_CIPHER, ocbc_pkg::byte_t'($urandom), b, 1'b0, 8'd0);
			sent_items++;
		end else if ($urandom_range(1) == 0) begin
			send_item(ocbc_pkg::OP_LOAD_ROT, ocbc_pkg::byte_t'($urandom),
				ocbc_pkg::byte_t'($urandom), 1'b0, 8'd0);
			sent_items++;
		end else begin
			// reflector entries go in as a swapped pair
			i = ocbc_pkg::byte_t'($urandom);
			j = ocbc_pkg::byte_t'($urandom);
			send_item(ocbc_pkg::OP_LOAD_REF, i, j, 1'b0, 8'd0);
			send_item(ocbc_pkg::OP_LOAD_REF, j, i, 1'b0, 8'd0);
			sent_items += 2;
		end
	endtask

	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= recv_gap_pct);

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_out.size() == 0) begin
				$display("%0t: expected no result, actual out_byte %02h", $time, out_byte);
				errors++;
			end else begin
				out_want = pending_out.pop_front();
				if (out_byte !== out_want) begin
					$display("%0t: out_byte expected %02h actual %02h",
						$time, out_want, out_byte);
					errors++;
				end
			end
		end
	end

	// Watchdog: cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else if (quiet_cycles + 1 >= STALL_LIMIT) begin
				$display("simulation failed");
				$finish;
			end else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_gap_pct = 22;
		recv_gap_pct = 68;
		foreach (DIRECTED[k])
			send_item(DIRECTED[k].op, DIRECTED[k].idx, DIRECTED[k].val,
				DIRECTED[k].typed, DIRECTED[k].out);
		drain();

		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin send_gap_pct = 22; recv_gap_pct = 68; end
				1: begin send_gap_pct = 68; recv_gap_pct = 22; end
				default: begin send_gap_pct = 0; recv_gap_pct = 0; end
			endcase
			sent_items = 0;
			while (sent_items < PHASE_ITEMS)
				random_item();
			// hold off until every expected result has been received
			drain();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0 && pending_out.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
